// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/dfr_pkg.sv =====
// Types, constants and FIPS 46 tables for the DES Feistel round block.
// No dependencies.
package dfr_pkg;

  localparam logic [3:0] LAST_ROUND = 4'd15;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_ROUND = 1'b1
  } action_t;

  typedef struct packed {
    logic [31:0] left_half;
    logic [31:0] right_half;
  } halves_t;

  localparam logic [6:0] IP_TABLE [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [5:0] E_TABLE [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TABLE [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // Indexed by {row, column} = {b5, b0, b4..b1} of the six-bit group.
  localparam logic [3:0] SBOX_TABLE [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

endpackage

// ===== hw/rtl/dfr_if.sv =====
// Valid/ready channel interfaces for the DES Feistel round block.
// No dependencies.
interface dfr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] block_data;
  logic [47:0] round_key;
  logic [3:0]  round_index;

  modport source (output valid, action, block_data, round_key, round_index, input ready);
  modport sink   (input valid, action, block_data, round_key, round_index, output ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_out;
  logic [31:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ===== hw/rtl/dfr_ip.sv =====
// DES initial permutation of a 64-bit block, split into halves.
// Depends on dfr_pkg.
module dfr_ip (
  input  logic [63:0]      block_data,
  output dfr_pkg::halves_t halves
);

  logic [63:0] permuted;

  // Output bit i (MSB first) takes input bit IP_TABLE[i] (MSB first).
  always_comb begin
    permuted = '0;
    for (int i = 0; i < 64; i++) begin
      permuted[63 - i] = block_data[6'(7'd64 - dfr_pkg::IP_TABLE[i])];
    end
  end

  assign halves.left_half  = permuted[63:32];
  assign halves.right_half = permuted[31:0];

endmodule

// ===== hw/rtl/dfr_feistel.sv =====
// One DES round: f function (E, key mix, S-boxes, P) and half update.
// Depends on dfr_pkg.
module dfr_feistel (
  input  dfr_pkg::halves_t cur,
  input  logic [47:0]      round_key,
  input  logic [3:0]       round_index,
  output dfr_pkg::halves_t nxt
);

  logic [47:0] expanded;
  logic [47:0] mixed_key;
  logic [31:0] sbox_out;
  logic [31:0] f_out;
  logic [31:0] mixed;

  always_comb begin
    expanded = '0;
    for (int i = 0; i < 48; i++) begin
      expanded[47 - i] = cur.right_half[5'(6'd32 - dfr_pkg::E_TABLE[i])];
    end
  end

  assign mixed_key = expanded ^ round_key;

  // Each six-bit group picks row {b5,b0} and column b4..b1.
  always_comb begin
    logic [5:0] six;
    sbox_out = '0;
    for (int b = 0; b < 8; b++) begin
      six = mixed_key[47 - 6 * b -: 6];
      sbox_out[31 - 4 * b -: 4] = dfr_pkg::SBOX_TABLE[b][{six[5], six[0], six[4:1]}];
    end
  end

  always_comb begin
    f_out = '0;
    for (int i = 0; i < 32; i++) begin
      f_out[31 - i] = sbox_out[5'(6'd32 - dfr_pkg::P_TABLE[i])];
    end
  end

  assign mixed = cur.left_half ^ f_out;

  // Swap halves except on the last round.
  always_comb begin
    if (round_index == dfr_pkg::LAST_ROUND) begin
      nxt.left_half  = mixed;
      nxt.right_half = cur.right_half;
    end else begin
      nxt.left_half  = cur.right_half;
      nxt.right_half = mixed;
    end
  end

endmodule

// ===== hw/rtl/des_feistel_round_top.sv =====
// DES Feistel round block: input register, IP / round logic, state-and-result register.
// Depends on dfr_pkg, dfr_if, dfr_ip and dfr_feistel.
//
// Usage:
//   in_ch  (sink): one item per transfer. action = load pushes block_data
//          through the DES initial permutation into the left/right halves;
//          action = round runs one Feistel round with round_key on the held
//          halves, swapping them unless round_index is the last round (15).
//   out_ch (source): one result per item, carrying both halves afterwards.
//   Path: an unstalled item passes through the input register and then the
//   half registers, whose contents drive out_ch.
//   Throughput: one item per cycle while out_ch does not stall; the round logic
//   between the input register and the half registers is a single pass, and each
//   item sees the halves left by the item before it.
//   Stall: the half registers double as the result register; while out_ch
//   stalls, hold the result and the waiting item, and drop in_ch ready once
//   the input register is full too.
//   Reset: rst_n (synchronous, active low) clears both halves to zero and
//   empties both registers; a round before any load works on zero halves.
module des_feistel_round_top (
  input  logic      clk,
  input  logic      rst_n,
  dfr_in_if.sink    in_ch,
  dfr_out_if.source out_ch
);

  // Input register
  logic        in_valid_r;
  logic        action_r;
  logic [63:0] block_r;
  logic [47:0] key_r;
  logic [3:0]  index_r;

  // Halves: architectural state and output payload at once
  dfr_pkg::halves_t halves_r;
  dfr_pkg::halves_t halves_nxt;
  logic             out_valid_r;

  dfr_pkg::halves_t load_halves;
  dfr_pkg::halves_t round_halves;

  logic in_xfer;
  logic advance;

  // Advance a held input item when the result slot is empty or being taken this cycle.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  dfr_ip u_ip (
    .block_data (block_r),
    .halves     (load_halves)
  );

  dfr_feistel u_feistel (
    .cur         (halves_r),
    .round_key   (key_r),
    .round_index (index_r),
    .nxt         (round_halves)
  );

  always_comb begin
    unique case (dfr_pkg::action_t'(action_r))
      dfr_pkg::ACT_LOAD:  halves_nxt = load_halves;
      dfr_pkg::ACT_ROUND: halves_nxt = round_halves;
      default:            halves_nxt = halves_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      action_r <= in_ch.action;
      block_r  <= in_ch.block_data;
      key_r    <= in_ch.round_key;
      index_r  <= in_ch.round_index;
    end
  end

  // Halves are state, so reset clears them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halves_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        halves_r <= halves_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = halves_r.left_half;
  assign out_ch.right_out = halves_r.right_half;

endmodule

// ===== hw/rtl/dfr_checker.sv =====
// Port-level checker for des_feistel_round_top, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] left_out,
  input logic [31:0] right_out
);

  // Reset empties the result slot.
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)

  // Input backpressure only comes from a stalled, full result slot.
  `ASSERT_CLK(a_ready_cause, clk, rst_n, !in_ready |-> (out_valid && !out_ready))

  // A stalled result holds its halves.
  `ASSERT_CLK(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable({left_out, right_out})))

  // An offered item with a full input stage is blocked until the output moves.
  `ASSERT_CLK(a_block_wait, clk, rst_n, (in_valid && !in_ready) |-> !out_ready)

endmodule

bind des_feistel_round_top dfr_checker u_dfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .left_out  (out_ch.left_out),
  .right_out (out_ch.right_out)
);

// ===== tb/dfr_round_checker.sv =====
// Scoreboard for the DES Feistel round block: watches both channels, predicts each result.
// Depends on dfr_pkg (types and FIPS 46 tables) and the channel interfaces in dfr_if.
`timescale 1ns / 1ps

module dfr_round_checker (
  input  logic      clk,
  input  logic      rst_n,
  dfr_in_if         in_mon,
  dfr_out_if        out_mon,
  output int        fail_count,
  output int        pending_count
);

  dfr_pkg::halves_t expected_halves [$];
  logic [31:0]      cur_left;
  logic [31:0]      cur_right;

  function automatic logic [63:0] initial_perm(logic [63:0] blk);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63 - i] = blk[6'(7'd64 - dfr_pkg::IP_TABLE[i])];
    return r;
  endfunction

  function automatic logic [31:0] round_mix(logic [31:0] rh, logic [47:0] key);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47 - i] = rh[5'(6'd32 - dfr_pkg::E_TABLE[i])];
    x = x ^ key;
    for (int b = 0; b < 8; b++) begin
      six = x[47 - 6 * b -: 6];
      s[31 - 4 * b -: 4] = dfr_pkg::SBOX_TABLE[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31 - i] = s[5'(6'd32 - dfr_pkg::P_TABLE[i])];
    return p;
  endfunction

  always @(posedge clk) begin
    dfr_pkg::halves_t got;
    dfr_pkg::halves_t want;
    logic [63:0]      perm;
    logic [31:0]      mixed;
    if (!rst_n) begin
      cur_left  = '0;
      cur_right = '0;
      expected_halves.delete();
    end else begin
      // retire the oldest expectation against the result transfer
      if (out_mon.valid && out_mon.ready) begin
        got.left_half  = out_mon.left_out;
        got.right_half = out_mon.right_out;
        if (expected_halves.size() == 0) begin
          $display("%0t: unexpected result left %h right %h", $time,
                   got.left_half, got.right_half);
          fail_count++;
        end else begin
          want = expected_halves.pop_front();
          if (got.left_half !== want.left_half) begin
            $display("%0t: left_out mismatch expected %h actual %h", $time,
                     want.left_half, got.left_half);
            fail_count++;
          end
          if (got.right_half !== want.right_half) begin
            $display("%0t: right_out mismatch expected %h actual %h", $time,
                     want.right_half, got.right_half);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (dfr_pkg::action_t'(in_mon.action) == dfr_pkg::ACT_LOAD) begin
          perm      = initial_perm(in_mon.block_data);
          cur_left  = perm[63:32];
          cur_right = perm[31:0];
        end else begin
          mixed = cur_left ^ round_mix(cur_right, in_mon.round_key);
          if (in_mon.round_index == dfr_pkg::LAST_ROUND) begin
            cur_left = mixed;
          end else begin
            cur_left  = cur_right;
            cur_right = mixed;
          end
        end
        want.left_half  = cur_left;
        want.right_half = cur_right;
        expected_halves.push_back(want);
      end
    end
    pending_count <= expected_halves.size();
  end

endmodule

// ===== tb/des_feistel_round_top_test.sv =====
// Top of the DES Feistel round testbench: clock, reset, stimulus, stall patterns, verdict.
// Depends on dfr_pkg, dfr_if, the block des_feistel_round_top and dfr_round_checker.
`timescale 1ns / 1ps

module des_feistel_round_top_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 560;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   fail_count;
  int   pending_count;
  int   quiet_cycles;

  dfr_in_if  in_ch ();
  dfr_out_if out_ch ();

  des_feistel_round_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker sees the same wires as the block and owns all prediction.
  dfr_round_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver: drop ready at random according to the current stall rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the transfer. Valid is left high on
  // return so back-to-back items never see it lowered and raised in one step.
  task automatic send_item(dfr_pkg::action_t act, logic [63:0] blk, logic [47:0] key,
                           logic [3:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.block_data  <= blk;
    in_ch.round_key   <= key;
    in_ch.round_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Hold off the sender until every predicted result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Mostly complete encryptions (one load then rounds 0..15 in order), with
  // the rest as cut-short sequences, out-of-order rounds and random noise.
  task automatic run_random_phase(int n_items);
    int sent;
    int pick;
    int n_rounds;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(dfr_pkg::ACT_LOAD, rand64(), rand48(), 4'($urandom_range(15)));
        for (int r = 0; r < 16; r++) begin
          send_item(dfr_pkg::ACT_ROUND, rand64(), rand48(), 4'(r));
        end
        sent += 17;
      end else if (pick < 85) begin
        n_rounds = $urandom_range(1, 15);
        send_item(dfr_pkg::ACT_LOAD, rand64(), rand48(), 4'($urandom_range(15)));
        for (int r = 0; r < n_rounds; r++) begin
          send_item(dfr_pkg::ACT_ROUND, rand64(), rand48(), 4'(r));
        end
        sent += n_rounds + 1;
      end else if (pick < 93) begin
        n_rounds = $urandom_range(1, 6);
        for (int r = 0; r < n_rounds; r++) begin
          send_item(dfr_pkg::ACT_ROUND, rand64(), rand48(), 4'($urandom_range(15)));
        end
        sent += n_rounds;
      end else begin
        send_item(dfr_pkg::action_t'($urandom_range(1)), rand64(), rand48(),
                  4'($urandom_range(15)));
        sent += 1;
      end
    end
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.action      <= dfr_pkg::ACT_LOAD;
    in_ch.block_data  <= '0;
    in_ch.round_key   <= '0;
    in_ch.round_index <= '0;
    rst_n             <= 1'b0;
    send_idle_pct      = 13;
    recv_stall_pct     = 70;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rounds on the zero halves left by reset, before any load.
    send_item(dfr_pkg::ACT_ROUND, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 4'd0);
    send_item(dfr_pkg::ACT_ROUND, 64'h0, 48'hFFFF_FFFF_FFFF, dfr_pkg::LAST_ROUND);
    // Loads at the field extremes; key and index must be ignored.
    send_item(dfr_pkg::ACT_LOAD, 64'h0, 48'hFFFF_FFFF_FFFF, 4'd15);
    send_item(dfr_pkg::ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 4'd0);
    send_item(dfr_pkg::ACT_ROUND, 64'h0, 48'h0, dfr_pkg::LAST_ROUND);
    // Full round sequence on a known block with patterned keys.
    send_item(dfr_pkg::ACT_LOAD, 64'h0123_4567_89AB_CDEF, rand48(),
              4'($urandom_range(15)));
    for (int r = 0; r < 16; r++) begin
      case (r % 4)
        0: begin
          send_item(dfr_pkg::ACT_ROUND, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'(r));
        end
        1: begin
          send_item(dfr_pkg::ACT_ROUND, 64'h0, 48'h0, 4'(r));
        end
        2: begin
          send_item(dfr_pkg::ACT_ROUND, rand64(), 48'hAAAA_AAAA_AAAA, 4'(r));
        end
        default: begin
          send_item(dfr_pkg::ACT_ROUND, rand64(), 48'h5555_5555_5555, 4'(r));
        end
      endcase
    end

    run_random_phase(PHASE_ITEMS);
    drain_results();

    send_idle_pct  = 70;
    recv_stall_pct = 13;
    run_random_phase(PHASE_ITEMS);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_phase(PHASE_ITEMS);

    // Wait out the last results, then give the verdict.
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_if.sv
hw/rtl/dfr_ip.sv
hw/rtl/dfr_feistel.sv
hw/rtl/des_feistel_round_top.sv
hw/rtl/dfr_checker.sv
tb/dfr_round_checker.sv
tb/des_feistel_round_top_test.sv
